[rtl/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;

	localparam int MW    = 16;  // matrix entry width
	localparam int DW    = 17;  // off-diagonal sum or difference width
	localparam int QW    = 16;  // quaternion component width
	localparam int QUO_W = 15;  // quotient bits below the saturation point

	localparam logic [1:0] IDX_X = 2'd0;
	localparam logic [1:0] IDX_Y = 2'd1;
	localparam logic [1:0] IDX_Z = 2'd2;
	localparam logic [1:0] IDX_W = 2'd3;

	localparam logic signed [QW-1:0] Q_MAX = 16'sh7fff;
	localparam logic signed [QW-1:0] Q_MIN = -16'sh8000;

	typedef logic signed [DW-1:0] diff_t;

	// Sideband that travels with the square root: chosen index, invalid
	// flag and the three numerators in increasing component order.
	typedef struct packed {
		logic [1:0] idx;
		logic       inv;
		diff_t      da;
		diff_t      db;
		diff_t      dc;
	} side_t;

endpackage
`default_nettype wire

[rtl/rotation_matrix_to_quaternion_unit.sv]
`default_nettype none
// Channel   Handshake              Payload
// request   req_valid, req_stall   m11 m12 m13 m21 m22 m23 m31 m32 m33
// result    res_valid, res_stall   quat_x quat_y quat_z quat_w largest_index invalid
//
// One request enters per cycle while the result is not stalled. RW =
// (max(FRAC_BITS,17) + FRAC_BITS + 3) / 2 rounded down is the depth of the
// one-bit-per-stage square root, which sits between the front stages and the
// divider; the divider adds one saturation check stage and fifteen quotient stages.
// Reset clears only the valid bits. A stalled result freezes the whole pipe;
// a new request is still taken whenever the result register is empty or leaving.
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic signed [rmq_pkg::MW-1:0] m11,
	input  wire logic signed [rmq_pkg::MW-1:0] m12,
	input  wire logic signed [rmq_pkg::MW-1:0] m13,
	input  wire logic signed [rmq_pkg::MW-1:0] m21,
	input  wire logic signed [rmq_pkg::MW-1:0] m22,
	input  wire logic signed [rmq_pkg::MW-1:0] m23,
	input  wire logic signed [rmq_pkg::MW-1:0] m31,
	input  wire logic signed [rmq_pkg::MW-1:0] m32,
	input  wire logic signed [rmq_pkg::MW-1:0] m33,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic signed [rmq_pkg::QW-1:0]      quat_x,
	output logic signed [rmq_pkg::QW-1:0]      quat_y,
	output logic signed [rmq_pkg::QW-1:0]      quat_z,
	output logic signed [rmq_pkg::QW-1:0]      quat_w,
	output logic [1:0]                         largest_index,
	output logic                               invalid
);
	import rmq_pkg::*;

	localparam int EW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
	localparam int NW = EW - 1 + FRAC_BITS;
	localparam int RW = (NW + 1) / 2;

	logic                 en;
	logic                 fr_valid;
	logic signed [EW-1:0] fr_e;
	side_t                fr_side;
	logic [NW-1:0]        sq_n;
	logic                 sq_valid;
	logic [RW-1:0]        sq_root;
	side_t                sq_side;
	logic                 dv_valid;
	logic signed [QW-1:0] dv_a, dv_b, dv_c, dv_v;
	logic [1:0]           dv_idx;
	logic                 dv_inv;

	logic signed [QW-1:0] qx_d, qy_d, qz_d, qw_d;
	logic                 valid_q;
	logic signed [QW-1:0] qx_q, qy_q, qz_q, qw_q;
	logic [1:0]           idx_q;
	logic                 inv_q;

	// advance unless a held result is stalled
	assign en        = !valid_q || !res_stall;
	assign req_stall = !en;

	rmq_front #(.FRAC_BITS(FRAC_BITS), .EW(EW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.m11       (m11),
		.m12       (m12),
		.m13       (m13),
		.m21       (m21),
		.m22       (m22),
		.m23       (m23),
		.m31       (m31),
		.m32       (m32),
		.m33       (m33),
		.out_valid (fr_valid),
		.e_big     (fr_e),
		.side      (fr_side)
	);

	// a negative candidate is flagged invalid; feed zero to the root
	assign sq_n = fr_e[EW-1] ? '0 : (NW'(fr_e[EW-2:0]) << FRAC_BITS);

	rmq_sqrt #(.NW(NW), .RW(RW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.n         (sq_n),
		.side_in   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	rmq_div #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.side_in   (sq_side),
		.out_valid (dv_valid),
		.q_a       (dv_a),
		.q_b       (dv_b),
		.q_c       (dv_c),
		.v_sat     (dv_v),
		.idx       (dv_idx),
		.inv       (dv_inv)
	);

	always_comb begin
		unique case (dv_idx)
			IDX_X: begin
				qx_d = dv_v; qy_d = dv_a; qz_d = dv_b; qw_d = dv_c;
			end
			IDX_Y: begin
				qx_d = dv_a; qy_d = dv_v; qz_d = dv_b; qw_d = dv_c;
			end
			IDX_Z: begin
				qx_d = dv_a; qy_d = dv_b; qz_d = dv_v; qw_d = dv_c;
			end
			default: begin
				qx_d = dv_a; qy_d = dv_b; qz_d = dv_c; qw_d = dv_v;
			end
		endcase
		if (dv_inv) begin
			qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q  <= qx_d;
			qy_q  <= qy_d;
			qz_q  <= qz_d;
			qw_q  <= qw_d;
			idx_q <= dv_idx;
			inv_q <= dv_inv;
		end
	end

	assign res_valid     = valid_q;
	assign quat_x        = qx_q;
	assign quat_y        = qy_q;
	assign quat_z        = qz_q;
	assign quat_w        = qw_q;
	assign largest_index = idx_q;
	assign invalid       = inv_q;

endmodule
`default_nettype wire

[rtl/rmq_front.sv]
`default_nettype none
module rmq_front #(
	parameter int FRAC_BITS = 14,
	parameter int EW        = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [rmq_pkg::MW-1:0] m11,
	input  wire logic signed [rmq_pkg::MW-1:0] m12,
	input  wire logic signed [rmq_pkg::MW-1:0] m13,
	input  wire logic signed [rmq_pkg::MW-1:0] m21,
	input  wire logic signed [rmq_pkg::MW-1:0] m22,
	input  wire logic signed [rmq_pkg::MW-1:0] m23,
	input  wire logic signed [rmq_pkg::MW-1:0] m31,
	input  wire logic signed [rmq_pkg::MW-1:0] m32,
	input  wire logic signed [rmq_pkg::MW-1:0] m33,
	output logic                               out_valid,
	output logic signed [EW-1:0]               e_big,
	output rmq_pkg::side_t                     side
);
	import rmq_pkg::*;

	localparam logic signed [EW-1:0] ONE = {{(EW-1){1'b0}}, 1'b1} << FRAC_BITS;

	logic                 valid_s1;
	logic signed [EW-1:0] ex_s1, ey_s1, ez_s1, ew_s1;
	diff_t                sxy_s1, sxz_s1, syz_s1, dx_s1, dy_s1, dz_s1;

	logic                 valid_s2;
	logic signed [EW-1:0] ebig_s2;
	side_t                side_s2;

	logic [1:0]           big;
	logic signed [EW-1:0] best;
	side_t                side_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1  <= ONE + EW'(m11) - EW'(m22) - EW'(m33);
			ey_s1  <= ONE - EW'(m11) + EW'(m22) - EW'(m33);
			ez_s1  <= ONE - EW'(m11) - EW'(m22) + EW'(m33);
			ew_s1  <= ONE + EW'(m11) + EW'(m22) + EW'(m33);
			sxy_s1 <= DW'(m12) + DW'(m21);
			sxz_s1 <= DW'(m31) + DW'(m13);
			syz_s1 <= DW'(m23) + DW'(m32);
			dx_s1  <= DW'(m23) - DW'(m32);
			dy_s1  <= DW'(m31) - DW'(m13);
			dz_s1  <= DW'(m12) - DW'(m21);
			ebig_s2 <= best;
			side_s2 <= side_d;
		end
	end

	// strict greater-than keeps the lowest index on ties
	always_comb begin
		big  = IDX_X;
		best = ex_s1;
		if (ey_s1 > best) begin
			big  = IDX_Y;
			best = ey_s1;
		end
		if (ez_s1 > best) begin
			big  = IDX_Z;
			best = ez_s1;
		end
		if (ew_s1 > best) begin
			big  = IDX_W;
			best = ew_s1;
		end
	end

	always_comb begin
		side_d.idx = big;
		side_d.inv = best[EW-1];
		unique case (big)
			IDX_X: begin
				side_d.da = sxy_s1;
				side_d.db = sxz_s1;
				side_d.dc = dx_s1;
			end
			IDX_Y: begin
				side_d.da = sxy_s1;
				side_d.db = syz_s1;
				side_d.dc = dy_s1;
			end
			IDX_Z: begin
				side_d.da = sxz_s1;
				side_d.db = syz_s1;
				side_d.dc = dz_s1;
			end
			default: begin
				side_d.da = dx_s1;
				side_d.db = dy_s1;
				side_d.dc = dz_s1;
			end
		endcase
	end

	assign out_valid = valid_s2;
	assign e_big     = ebig_s2;
	assign side      = side_s2;

endmodule
`default_nettype wire

[rtl/rmq_sqrt.sv]
`default_nettype none
module rmq_sqrt #(
	parameter int NW = 33,
	parameter int RW = 17
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [NW-1:0]  n,
	input  rmq_pkg::side_t      side_in,
	output logic                out_valid,
	output logic [RW-1:0]       root,
	output rmq_pkg::side_t      side_out
);
	import rmq_pkg::*;

	localparam int TW = 2*RW + 1;

	logic          valid_s [1:RW];
	logic [RW-1:0] root_s  [1:RW];
	logic [TW-1:0] rem_s   [1:RW-1];
	side_t         side_s  [1:RW];

	// one root bit per stage, most significant first
	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int B = RW - 1 - i;
		logic          v_in;
		logic [RW-1:0] r_in;
		logic [TW-1:0] rem_in;
		side_t         sd_in;
		logic [TW-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign r_in   = '0;
			assign rem_in = TW'(n);
			assign sd_in  = side_in;
		end else begin : g_next
			assign v_in   = valid_s[i];
			assign r_in   = root_s[i];
			assign rem_in = rem_s[i];
			assign sd_in  = side_s[i];
		end

		assign trial = (TW'(r_in) << (B + 1)) + (TW'(1) << (2 * B));
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[i+1] <= r_in | (RW'(ge) << B);
				side_s[i+1] <= sd_in;
			end
		end

		if (i < RW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= ge ? rem_in - trial : rem_in;
				end
			end
		end
	end

	assign out_valid = valid_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];

endmodule
`default_nettype wire

[rtl/rmq_div.sv]
`default_nettype none
module rmq_div #(
	parameter int FRAC_BITS = 14,
	parameter int RW        = 17
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [RW-1:0]                 root,
	input  rmq_pkg::side_t                     side_in,
	output logic                               out_valid,
	output logic signed [rmq_pkg::QW-1:0]      q_a,
	output logic signed [rmq_pkg::QW-1:0]      q_b,
	output logic signed [rmq_pkg::QW-1:0]      q_c,
	output logic signed [rmq_pkg::QW-1:0]      v_sat,
	output logic [1:0]                         idx,
	output logic                               inv
);
	import rmq_pkg::*;

	localparam int NDW = DW + FRAC_BITS;
	localparam int DVW = RW + 1;
	localparam int CW  = ((NDW > DVW + QUO_W) ? NDW : DVW + QUO_W) + 1;

	logic [DVW-1:0] dv;
	logic [31:0]    v_wide;
	diff_t          d_in [3];

	logic             valid_s [0:QUO_W];
	logic [DVW-1:0]   dv_s    [0:QUO_W-1];
	logic [QW-1:0]    vs_s    [0:QUO_W];
	logic [1:0]       idx_s   [0:QUO_W];
	logic             inv_s   [0:QUO_W];
	logic [CW-1:0]    rem_s   [3][0:QUO_W-1];
	logic [QUO_W-1:0] quo_s   [3][1:QUO_W];
	logic             neg_s   [3][0:QUO_W];
	logic             zero_s  [3][0:QUO_W];
	logic             ovf_s   [3][0:QUO_W];
	logic signed [QW-1:0] res [3];

	// divisor 4v with v = root/2
	assign dv     = {root[RW-1:1], 2'b00};
	assign v_wide = 32'(root[RW-1:1]);
	assign d_in[0] = side_in.da;
	assign d_in[1] = side_in.db;
	assign d_in[2] = side_in.dc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0]  <= dv;
			vs_s[0]  <= (v_wide > 32'd32767) ? QW'(Q_MAX) : v_wide[QW-1:0];
			idx_s[0] <= side_in.idx;
			inv_s[0] <= side_in.inv;
		end
	end

	for (genvar j = 1; j <= QUO_W; j++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= valid_s[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				vs_s[j]  <= vs_s[j-1];
				idx_s[j] <= idx_s[j-1];
				inv_s[j] <= inv_s[j-1];
			end
		end
		if (j < QUO_W) begin : g_dv
			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[j] <= dv_s[j-1];
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic          neg;
		logic [DW-1:0] mag;
		logic [CW-1:0] num;

		assign neg = d_in[l][DW-1];
		assign mag = neg ? DW'(-d_in[l]) : DW'(d_in[l]);
		assign num = CW'(mag) << FRAC_BITS;

		// quotient of 2^15 or more saturates, which also covers a zero divisor
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[l][0]  <= num;
				neg_s[l][0]  <= neg;
				zero_s[l][0] <= (mag == '0);
				ovf_s[l][0]  <= num >= (CW'(dv) << QUO_W);
			end
		end

		for (genvar j = 1; j <= QUO_W; j++) begin : g_step
			localparam int K = QUO_W - j;
			logic [CW-1:0]    trial;
			logic             ge;
			logic [QUO_W-1:0] quo_in;

			assign trial = CW'(dv_s[j-1]) << K;
			assign ge    = rem_s[l][j-1] >= trial;

			if (j == 1) begin : g_first
				assign quo_in = '0;
			end else begin : g_next
				assign quo_in = quo_s[l][j-1];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					quo_s[l][j]  <= quo_in | (QUO_W'(ge) << K);
					neg_s[l][j]  <= neg_s[l][j-1];
					zero_s[l][j] <= zero_s[l][j-1];
					ovf_s[l][j]  <= ovf_s[l][j-1];
				end
			end

			if (j < QUO_W) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[l][j] <= ge ? rem_s[l][j-1] - trial : rem_s[l][j-1];
					end
				end
			end
		end

		always_comb begin
			if (zero_s[l][QUO_W]) begin
				res[l] = '0;
			end else if (ovf_s[l][QUO_W]) begin
				res[l] = neg_s[l][QUO_W] ? Q_MIN : Q_MAX;
			end else if (neg_s[l][QUO_W]) begin
				res[l] = -$signed({1'b0, quo_s[l][QUO_W]});
			end else begin
				res[l] = $signed({1'b0, quo_s[l][QUO_W]});
			end
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign q_a       = res[0];
	assign q_b       = res[1];
	assign q_c       = res[2];
	assign v_sat     = vs_s[QUO_W];
	assign idx       = idx_s[QUO_W];
	assign inv       = inv_s[QUO_W];

endmodule
`default_nettype wire

[dv/rotation_matrix_to_quaternion_unit_test.sv]
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_test;
	import rmq_pkg::*;

	localparam int FRAC = 14;
	localparam int WATCH_LIMIT = 20000;

	typedef struct packed {
		logic signed [15:0] qx, qy, qz, qw;
		logic [1:0] idx;
		logic inv;
	} quat_t;

	class quat_scoreboard;
		quat_t pending[$];
		int errors;

		function longint isqrt(longint n);
			longint r, b;
			r = 0;
			b = longint'(1) <<< 62;
			while (b > n) b = b >>> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		function logic signed [15:0] clamp(longint v);
			if (v > 32767) return Q_MAX;
			if (v < -32768) return Q_MIN;
			return v[15:0];
		endfunction

		function logic signed [15:0] quarter_over(longint d, longint v);
			longint mag, q;
			if (v <= 0) begin
				if (d > 0) return Q_MAX;
				if (d < 0) return Q_MIN;
				return '0;
			end
			mag = (d < 0) ? -d : d;
			q = (mag <<< FRAC) / (v * 4);
			if (q > 40000) q = 40000;
			return clamp((d < 0) ? -q : q);
		endfunction

		function void note_request(logic signed [15:0] m[9]);
			longint a[9], e[4], v;
			logic signed [15:0] q[4];
			longint sxy, sxz, syz, dx, dy, dz;
			int big;
			quat_t r;
			for (int i = 0; i < 9; i++) a[i] = longint'(m[i]);
			e[0] = (longint'(1) <<< FRAC) + a[0] - a[4] - a[8];
			e[1] = (longint'(1) <<< FRAC) - a[0] + a[4] - a[8];
			e[2] = (longint'(1) <<< FRAC) - a[0] - a[4] + a[8];
			e[3] = (longint'(1) <<< FRAC) + a[0] + a[4] + a[8];
			big = 0;
			for (int i = 1; i < 4; i++) if (e[i] > e[big]) big = i;
			q = '{'0, '0, '0, '0};
			r.inv = 0;
			if (e[big] < 0) begin
				r.inv = 1;
			end else begin
				v = isqrt(e[big] <<< FRAC) >>> 1;
				sxy = a[1] + a[3]; sxz = a[6] + a[2]; syz = a[5] + a[7];
				dx = a[5] - a[7]; dy = a[6] - a[2]; dz = a[1] - a[3];
				q[big] = clamp(v);
				case (big)
					0: begin
						q[1] = quarter_over(sxy, v); q[2] = quarter_over(sxz, v);
						q[3] = quarter_over(dx, v);
					end
					1: begin
						q[0] = quarter_over(sxy, v); q[2] = quarter_over(syz, v);
						q[3] = quarter_over(dy, v);
					end
					2: begin
						q[0] = quarter_over(sxz, v); q[1] = quarter_over(syz, v);
						q[3] = quarter_over(dz, v);
					end
					default: begin
						q[0] = quarter_over(dx, v); q[1] = quarter_over(dy, v);
						q[2] = quarter_over(dz, v);
					end
				endcase
			end
			r.qx = q[0]; r.qy = q[1]; r.qz = q[2]; r.qw = q[3];
			r.idx = big[1:0];
			pending.push_back(r);
		endfunction

		function void check_result(quat_t got);
			quat_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.qx !== want.qx) mismatch("quat_x", want.qx, got.qx);
			if (got.qy !== want.qy) mismatch("quat_y", want.qy, got.qy);
			if (got.qz !== want.qz) mismatch("quat_z", want.qz, got.qz);
			if (got.qw !== want.qw) mismatch("quat_w", want.qw, got.qw);
			if (got.idx !== want.idx) mismatch("largest_index", want.idx, got.idx);
			if (got.inv !== want.inv) mismatch("invalid", want.inv, got.inv);
		endfunction

		function void mismatch(string f, longint w, longint g);
			$display("%0t: %s expected %0d actual %0d", $time, f, w, g);
			errors++;
		endfunction
	endclass

	logic clk, arst_n, req_valid, req_stall, res_valid, res_stall;
	logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0] largest_index;
	logic invalid;

	quat_scoreboard board;
	int send_idle, recv_idle, watch;
	bit hold_off, stim_done;

	rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// note requests and check results at the edge where they are taken
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			board.note_request('{m11, m12, m13, m21, m22, m23, m31, m32, m33});
		end
		if (arst_n && res_valid && !res_stall)
			board.check_result('{quat_x, quat_y, quat_z, quat_w, largest_index, invalid});
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) watch <= 0;
		else watch <= watch + 1;
	end

	always @(posedge clk) begin
		if (watch >= WATCH_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (hold_off) res_stall <= 1;
		else res_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic offer(logic signed [15:0] m[9]);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		{m11, m12, m13, m21, m22, m23, m31, m32, m33} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_entry();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 16384) - 8192);
			3: return '0;
			default: return 16'($urandom());
		endcase
	endfunction

	// mostly near-rotation (diagonal dominant along a random axis, small off-diagonals), else random entries
	task automatic random_item();
		logic signed [15:0] m[9];
		int ax;
		if ($urandom_range(3) == 0) begin
			for (int i = 0; i < 9; i++) m[i] = pick_entry();
		end else begin
			ax = $urandom_range(3);
			for (int i = 0; i < 9; i++) m[i] = 16'($urandom_range(0, 8192) - 4096);
			for (int i = 0; i < 3; i++)
				m[i * 4] = (ax == i || ax == 3) ? 16'($urandom_range(16384, 8192))
					: 16'(-$urandom_range(16384, 4096));
		end
		offer(m);
	endtask

	task automatic run_phase(int si, int ri, int n);
		send_idle = si;
		recv_idle = ri;
		for (int i = 0; i < n; i++) random_item();
	endtask

	initial begin
		board = new();
		req_valid = 0; res_stall = 0; hold_off = 0; watch = 0;
		{m11, m12, m13, m21, m22, m23, m31, m32, m33} = '0;
		send_idle = 0; recv_idle = 0;
		@(posedge arst_n);
		@(posedge clk);
		// identity, axis rotations, ties, all extremes, negative candidates
		offer('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
		offer('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
		offer('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
		offer('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
		offer('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		offer('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
		offer('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
		offer('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767});
		offer('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
		offer('{-5462, 100, -100, 200, -5461, 300, -300, 50, -5461});
		offer('{-8192, 5, 6, 7, -8192, 8, 9, 10, -8192});
		offer('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
		offer('{-16384, 32767, 0, -32768, 0, 0, 0, 0, 0});
		offer('{8192, 4000, -4000, 1234, 8192, -1234, 77, -77, 8192});
		offer('{0, 11585, 0, -11585, 0, 0, 0, 0, 16384});
		offer('{-32768, 1, 2, 3, 32767, 4, 5, 6, 32767});
		run_phase(22, 83, 500);
		run_phase(83, 22, 500);
		// long receiver hold-off while requests keep coming
		send_idle = 0; recv_idle = 0;
		hold_off = 1;
		fork
			begin
				repeat (150) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 100; i++) random_item();
		join
		run_phase(0, 0, 500);
		req_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (board.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
